### rtl/mbtcp_pkg.sv
package mbtcp_pkg;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HEADER = 2'd1,
    PH_PDU    = 2'd2
  } phase_t;

  localparam logic [1:0] FUNC_START   = 2'd0;
  localparam logic [1:0] FUNC_BYTE    = 2'd1;
  localparam logic [1:0] FUNC_TIMEOUT = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TIMEOUT   = 3'd1;
  localparam logic [2:0] ST_BAD_LEN   = 3'd2;
  localparam logic [2:0] ST_EXCEPTION = 3'd3;
  localparam logic [2:0] ST_SHORT     = 3'd4;

  localparam logic [2:0] DT_UINT16  = 3'd0;
  localparam logic [2:0] DT_INT16   = 3'd1;
  localparam logic [2:0] DT_INT32   = 3'd2;
  localparam logic [2:0] DT_UINT32  = 3'd3;
  localparam logic [2:0] DT_FLOAT32 = 3'd4;

  localparam logic [1:0] WO_BIG       = 2'd0;
  localparam logic [1:0] WO_WORD_SWAP = 2'd1;
  localparam logic [1:0] WO_BYTE_SWAP = 2'd2;
  localparam logic [1:0] WO_BOTH_SWAP = 2'd3;

  localparam logic [7:0] MBAP_LEN_LO = 8'h06;
  localparam logic [7:0] EXC_FLAG    = 8'h80;
  localparam logic [3:0] REQ_LAST    = 4'd11;

endpackage

### rtl/modbus_tcp_register_read_engine.sv
// Modbus TCP read request / reply engine.
// A received byte or timeout passes through stage 1 and then the stage 2 output.
// A start emits 12 request bytes through the same stages, one per cycle while
// out_stall is low; input is held off while those bytes are issued. Other items
// are taken, and results leave the output register, one per cycle unless stalled.
// Synchronous active-low reset clears phase, counters and the output pipeline.
module modbus_tcp_register_read_engine import mbtcp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_unit_id,
  input  logic [2:0]  in_fcode,
  input  logic [15:0] in_start_addr,
  input  logic [2:0]  in_dtype,
  input  logic [1:0]  in_word_order,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  out_tx_byte,
  output logic        out_last,
  output logic [2:0]  out_status,
  output logic [7:0]  out_exception_code,
  output logic [31:0] out_value_bits
);

  // parser state
  phase_t      phase_r;
  logic [15:0] txn_r;
  logic [8:0]  idx_r;
  logic [15:0] flen_r;
  logic [7:0]  fpb_r, rbc_r;
  logic [15:0] w0_r, w1_r;
  logic [2:0]  ltype_r;
  logic [1:0]  lorder_r;

  // request issue
  logic        tx_busy_r;
  logic [3:0]  tx_pos_r;
  logic [7:0]  req_unit_r;
  logic [2:0]  req_fc_r;
  logic [15:0] req_addr_r;

  // stage 1 (pre-conversion) and stage 2 (output)
  logic        s1_valid_r, s1_kind_r, s1_last_r, s1_conv_r, s1_neg_r;
  logic [7:0]  s1_tx_r, s1_exc_r;
  logic [2:0]  s1_status_r;
  logic [31:0] s1_mag_r;
  logic        s2_valid_r, s2_kind_r, s2_last_r;
  logic [7:0]  s2_tx_r, s2_exc_r;
  logic [2:0]  s2_status_r;
  logic [31:0] s2_val_r;

  logic adv, acc;
  assign adv      = !s2_valid_r || !out_stall;
  assign in_stall = !adv || tx_busy_r;
  assign acc      = in_valid && !in_stall;

  // byte parse
  logic [15:0] flen_nxt, pl, w0_nxt, w1_nxt, hi, lo;
  logic [8:0]  idx_inc;
  logic [7:0]  fpb_nxt, rbc_nxt;
  logic [3:0]  qty2;
  logic [31:0] joined;
  always_comb begin
    idx_inc  = idx_r + 9'd1;
    flen_nxt = flen_r;
    fpb_nxt  = fpb_r;
    rbc_nxt  = rbc_r;
    w0_nxt   = w0_r;
    w1_nxt   = w1_r;
    if (phase_r == PH_HEADER) begin
      if (idx_r == 9'd4) flen_nxt = {in_rx_byte, 8'h00};
      else if (idx_r == 9'd5) flen_nxt = {flen_r[15:8], in_rx_byte};
    end else begin
      case (idx_r)
        9'd0: fpb_nxt = in_rx_byte;
        9'd1: rbc_nxt = in_rx_byte;
        9'd2: w0_nxt = {in_rx_byte, w0_r[7:0]};
        9'd3: w0_nxt = {w0_r[15:8], in_rx_byte};
        9'd4: w1_nxt = {in_rx_byte, w1_r[7:0]};
        9'd5: w1_nxt = {w1_r[15:8], in_rx_byte};
        default: ;
      endcase
    end
    pl   = flen_nxt - 16'd1;
    qty2 = (ltype_r >= DT_INT32) ? 4'd4 : 4'd2;
    case (lorder_r)
      WO_WORD_SWAP: begin hi = w1_nxt; lo = w0_nxt; end
      WO_BYTE_SWAP: begin
        hi = {w0_nxt[7:0], w0_nxt[15:8]}; lo = {w1_nxt[7:0], w1_nxt[15:8]};
      end
      WO_BOTH_SWAP: begin
        hi = {w1_nxt[7:0], w1_nxt[15:8]}; lo = {w0_nxt[7:0], w0_nxt[15:8]};
      end
      default: begin hi = w0_nxt; lo = w1_nxt; end
    endcase
    joined = {hi, lo};
  end

  // request byte mux
  logic [7:0] req_byte;
  always_comb begin
    case (tx_pos_r)
      4'd0:  req_byte = txn_r[15:8];
      4'd1:  req_byte = txn_r[7:0];
      4'd5:  req_byte = MBAP_LEN_LO;
      4'd6:  req_byte = req_unit_r;
      4'd7:  req_byte = {5'd0, req_fc_r};
      4'd8:  req_byte = req_addr_r[15:8];
      4'd9:  req_byte = req_addr_r[7:0];
      4'd11: req_byte = (ltype_r >= DT_INT32) ? 8'd2 : 8'd1;
      default: req_byte = 8'h00;
    endcase
  end

  // stage 1 next values and parser updates
  logic        s1_valid_nxt, s1_kind_nxt, s1_last_nxt, s1_conv_nxt, s1_neg_nxt;
  logic [7:0]  s1_tx_nxt, s1_exc_nxt;
  logic [2:0]  s1_status_nxt;
  logic [31:0] s1_mag_nxt;
  phase_t      phase_nxt;
  logic [8:0]  idx_nxt;
  always_comb begin
    s1_valid_nxt = 1'b0; s1_kind_nxt = 1'b1; s1_last_nxt = 1'b0;
    s1_conv_nxt = 1'b0; s1_neg_nxt = 1'b0; s1_tx_nxt = 8'h00; s1_exc_nxt = 8'h00;
    s1_status_nxt = ST_OK; s1_mag_nxt = 32'd0;
    phase_nxt = phase_r; idx_nxt = idx_r;
    if (tx_busy_r) begin
      s1_valid_nxt = 1'b1;
      s1_kind_nxt  = 1'b0;
      s1_tx_nxt    = req_byte;
      s1_last_nxt  = (tx_pos_r == REQ_LAST);
    end else if (acc) begin
      case (in_func)
        FUNC_START: begin
          phase_nxt = PH_HEADER;
          idx_nxt   = 9'd0;
        end
        FUNC_TIMEOUT: if (phase_r != PH_IDLE) begin
          phase_nxt     = PH_IDLE;
          s1_valid_nxt  = 1'b1;
          s1_status_nxt = ST_TIMEOUT;
        end
        FUNC_BYTE: begin
          if (phase_r == PH_HEADER) begin
            idx_nxt = idx_inc;
            if (idx_inc == 9'd7) begin
              if (pl == 16'd0 || pl > 16'd255) begin
                phase_nxt     = PH_IDLE;
                s1_valid_nxt  = 1'b1;
                s1_status_nxt = ST_BAD_LEN;
              end else begin
                phase_nxt = PH_PDU;
                idx_nxt   = 9'd0;
              end
            end
          end else if (phase_r == PH_PDU) begin
            idx_nxt = idx_inc;
            if ({7'd0, idx_inc} >= pl) begin
              phase_nxt    = PH_IDLE;
              s1_valid_nxt = 1'b1;
              if ((fpb_nxt & EXC_FLAG) != 8'h00) begin
                s1_status_nxt = ST_EXCEPTION;
                s1_exc_nxt    = rbc_nxt;
              end else if (rbc_nxt < {4'd0, qty2} || pl < 16'd2 + {12'd0, qty2}) begin
                s1_status_nxt = ST_SHORT;
              end else begin
                s1_conv_nxt = 1'b1;
                case (ltype_r)
                  DT_INT16: begin
                    s1_neg_nxt = w0_nxt[15];
                    s1_mag_nxt = w0_nxt[15] ? 32'h10000 - {16'd0, w0_nxt}
                                            : {16'd0, w0_nxt};
                  end
                  DT_INT32: begin
                    s1_neg_nxt = joined[31];
                    s1_mag_nxt = joined[31] ? 32'd0 - joined : joined;
                  end
                  DT_UINT32: s1_mag_nxt = joined;
                  DT_FLOAT32: begin
                    s1_conv_nxt = 1'b0;
                    s1_mag_nxt  = joined;
                  end
                  default: s1_mag_nxt = {16'd0, w0_nxt};
                endcase
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // normalize and round to single
  logic [4:0]  p;
  logic [31:0] norm;
  logic [24:0] mr;
  logic [7:0]  ex;
  logic [31:0] conv_bits;
  always_comb begin
    p = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (s1_mag_r[i]) p = i[4:0];
    end
    norm = s1_mag_r << (5'd31 - p);
    mr   = {1'b0, norm[31:8]};
    if (norm[7] && ((norm[6:0] != 7'd0) || norm[8])) mr = mr + 25'd1;
    ex = 8'd127 + {3'd0, p};
    if (mr[24]) begin
      ex = ex + 8'd1;
      mr = mr >> 1;
    end
    if (s1_mag_r == 32'd0) conv_bits = {s1_neg_r, 31'd0};
    else conv_bits = {s1_neg_r, ex, mr[22:0]};
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; txn_r <= 16'd0; idx_r <= 9'd0; flen_r <= 16'd0;
      fpb_r <= 8'd0; rbc_r <= 8'd0; w0_r <= 16'd0; w1_r <= 16'd0;
      ltype_r <= 3'd0; lorder_r <= 2'd0; tx_busy_r <= 1'b0; tx_pos_r <= 4'd0;
      s1_valid_r <= 1'b0; s2_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s1_valid_r;
      phase_r    <= phase_nxt;
      idx_r      <= idx_nxt;
      if (tx_busy_r) begin
        tx_pos_r <= tx_pos_r + 4'd1;
        if (tx_pos_r == REQ_LAST) tx_busy_r <= 1'b0;
      end else if (acc && in_func == FUNC_START) begin
        // latch request and clear reply state
        txn_r <= txn_r + 16'd1; ltype_r <= in_dtype; lorder_r <= in_word_order;
        tx_busy_r <= 1'b1; tx_pos_r <= 4'd0;
        flen_r <= 16'd0; fpb_r <= 8'd0; rbc_r <= 8'd0; w0_r <= 16'd0; w1_r <= 16'd0;
      end else if (acc && in_func == FUNC_BYTE && phase_r != PH_IDLE) begin
        flen_r <= flen_nxt; fpb_r <= fpb_nxt; rbc_r <= rbc_nxt;
        w0_r <= w0_nxt; w1_r <= w1_nxt;
      end
    end
  end

  // payload pipeline
  always_ff @(posedge clk) begin
    if (adv) begin
      if (acc && in_func == FUNC_START) begin
        req_unit_r <= in_unit_id; req_fc_r <= in_fcode; req_addr_r <= in_start_addr;
      end
      s1_kind_r <= s1_kind_nxt; s1_last_r <= s1_last_nxt; s1_conv_r <= s1_conv_nxt;
      s1_neg_r <= s1_neg_nxt; s1_tx_r <= s1_tx_nxt; s1_exc_r <= s1_exc_nxt;
      s1_status_r <= s1_status_nxt; s1_mag_r <= s1_mag_nxt;
      s2_kind_r <= s1_kind_r; s2_last_r <= s1_last_r; s2_tx_r <= s1_tx_r;
      s2_exc_r <= s1_exc_r; s2_status_r <= s1_status_r;
      s2_val_r <= s1_conv_r ? conv_bits : s1_mag_r;
    end
  end

  assign out_valid          = s2_valid_r;
  assign out_kind           = s2_kind_r;
  assign out_tx_byte        = s2_tx_r;
  assign out_last           = s2_last_r;
  assign out_status         = s2_status_r;
  assign out_exception_code = s2_exc_r;
  assign out_value_bits     = s2_val_r;

endmodule
